FILE: hw/rtl/ebmv_pkg.sv
package ebmv_pkg;

   // Shared multiplier operand width: 32-bit signed or unsigned values
   localparam int MUL_W = 33;

   // Fixed-point constants, Q2.30
   localparam logic [30:0] ONE30       = 31'h4000_0000;
   localparam logic [39:0] HALF_PI_Q30 = 40'd1686629713;

   // Register indexes of the configuration port
   localparam logic [3:0] REG_X_SCALE      = 4'd0;
   localparam logic [3:0] REG_Y_SCALE      = 4'd1;
   localparam logic [3:0] REG_X_FADE_SCALE = 4'd2;
   localparam logic [3:0] REG_Y_FADE_SCALE = 4'd3;
   localparam logic [3:0] REG_SPIKE_COS    = 4'd4;
   localparam logic [3:0] REG_SPIKE_SIN    = 4'd5;
   localparam logic [3:0] REG_SPIKE_HALF   = 4'd6;
   localparam logic [3:0] REG_MODE_FLAGS   = 4'd7;

   // Arctangent of 2^-i in Q2.30
   localparam logic [29:0] ATAN_TAB [30] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2
   };

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ATAN_INIT,
      ST_CORDIC,
      ST_FOLD_CHK,
      ST_ROT_A,
      ST_ROT_B,
      ST_ROT_C,
      ST_ROT_D,
      ST_ROT_E,
      ST_SC0,
      ST_SC1,
      ST_SC2,
      ST_SC3,
      ST_SC4,
      ST_RM0,
      ST_RM1,
      ST_RM2,
      ST_DIV,
      ST_RAMP_FIN,
      ST_FM0,
      ST_FM1,
      ST_DONE
   } state_type;

endpackage

FILE: hw/rtl/elliptic_brush_mask_value.sv
// Sequence: an empty brush goes from the accepted beat straight to the result; other beats
//   pass the scaling steps and, for most of them, the shared restoring divider, plus the
//   arctangent (cut short at the origin) and a spike fold per rotation in spiked mode.
// Throughput: one beat at a time; the sequencer around the one registered multiplier and
//   the divider sets the rate. A finished result waits in the output register.
// Reset: synchronous, active high; resets the sequencer, the output valid and the configuration registers.
module elliptic_brush_mask_value #(
   parameter int MAX_SPIKES = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_pos_x,
   input  logic signed [COORD_BITS-1:0] req_pos_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_mask_value,
   input  logic                         csr_we,
   input  logic [3:0]                   csr_index,
   input  logic [31:0]                  csr_wdata
);

   localparam int EXT  = (COORD_BITS < 31) ? 31 - COORD_BITS : 0;
   localparam int SH   = 4 + EXT;
   localparam int KMAX = MAX_SPIKES / 2;
   localparam int KW   = $clog2(KMAX + 1);
   localparam int PW   = 2 * ebmv_pkg::MUL_W;

   // Configuration registers
   logic [31:0] x_scale_ff, y_scale_ff, x_fade_scale_ff, y_fade_scale_ff;
   logic [31:0] spike_cos_ff, spike_sin_ff, spike_half_ff;
   logic [2:0]  mode_flags_ff;

   // Sequencer and datapath registers
   ebmv_pkg::state_type state_ff, state_in;
   logic signed [31:0] xr_ff, xr_in, yr_ff, yr_in, nx_ff, nx_in;
   logic signed [35:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [39:0] ang_ff, ang_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [KW-1:0]      k_ff, k_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic [31:0]        u_ff, u_in, v_ff, v_in;
   logic [30:0]        n30_ff, n30_in;
   logic [63:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [30:0]        bits_ff, bits_in, quo_ff, quo_in;
   logic               fade_ff, fade_in;
   logic [7:0]         res_ff, res_in;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_mask_ff;

   // Shared multiplier
   logic signed [ebmv_pkg::MUL_W-1:0] op_a, op_b;
   logic signed [PW-1:0]              prod;

   ebmv_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   function automatic logic signed [31:0] sat_c(input logic signed [39:0] v);
      logic signed [39:0] lim;
      lim = 40'sd2147483647;
      if (v > lim) begin
         sat_c = 32'sd2147483647;
      end else if (v < -lim) begin
         sat_c = -32'sd2147483647;
      end else begin
         sat_c = v[31:0];
      end
   endfunction

   // Common datapath terms
   logic               req_acc, out_free;
   logic signed [33:0] px_ext, py_ext, py_abs;
   logic [63:0]        prod_u, scaled, sum_u;
   logic [31:0]        sat_u, xr_mag, yr_mag;
   logic signed [PW-1:0] rot_xs, rot_ys;
   logic signed [35:0] dx, dy;
   logic               ang_big, nn_big, tiny, div_ge;
   logic [33:0]        f30, den, fnum;
   logic [63:0]        num;
   logic [30:0]        m_val;
   logic [64:0]        rem2, diff;
   logic [30:0]        rd;
   logic [38:0]        ramp_prod;
   logic [33:0]        ft;
   logic [41:0]        ft255;
   logic [31:0]        scale_a, scale_b;

   assign req_stall = (state_ff != ebmv_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign px_ext  = 34'(req_pos_x) <<< EXT;
   assign py_ext  = 34'(req_pos_y) <<< EXT;
   assign py_abs  = (py_ext < 0) ? -py_ext : py_ext;

   assign prod_u  = prod[63:0];
   assign scaled  = prod_u >> SH;
   assign sat_u   = (scaled > 64'h8000_0000) ? 32'h8000_0000 : scaled[31:0];
   assign sum_u   = acc_ff[63:0] + prod_u;
   assign xr_mag  = (xr_ff < 0) ? 32'(-33'(xr_ff)) : 32'(xr_ff);
   assign yr_mag  = (yr_ff < 0) ? 32'(-33'(yr_ff)) : 32'(yr_ff);

   assign rot_xs  = acc_ff - prod + (PW'(1) <<< 29);
   assign rot_ys  = acc_ff + prod + (PW'(1) <<< 29);

   assign dx      = cy_ff >>> cnt_ff;
   assign dy      = cx_ff >>> cnt_ff;
   assign ang_big = ang_ff > $signed({8'b0, spike_half_ff});

   assign nn_big  = sum_u > 64'h1000_0000_0000_0000;
   assign f30     = sum_u[63:30];
   assign den     = f30 - 34'(n30_ff);
   assign fnum    = f30 - 34'(ebmv_pkg::ONE30);
   assign num     = 64'(fnum) << 30;
   assign m_val   = ebmv_pkg::ONE30 - n30_ff;
   assign tiny    = mode_flags_ff[2] || ({m_val, 1'b0} > x_scale_ff)
                    || ({m_val, 1'b0} > y_scale_ff);

   assign rem2    = {rem_ff, bits_ff[30]};
   assign div_ge  = rem2 >= {1'b0, dvs_ff};
   assign diff    = rem2 - {1'b0, dvs_ff};

   assign rd        = ebmv_pkg::ONE30 - quo_ff;
   assign ramp_prod = {rd, 8'b0} - {8'b0, rd};
   assign ft        = prod_u[63:30];
   assign ft255     = {ft, 8'b0} - {8'b0, ft};

   assign scale_a = fade_ff ? x_fade_scale_ff : x_scale_ff;
   assign scale_b = fade_ff ? y_fade_scale_ff : y_scale_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_scale_ff      <= '0;
         y_scale_ff      <= '0;
         x_fade_scale_ff <= '0;
         y_fade_scale_ff <= '0;
         spike_cos_ff    <= 32'h4000_0000;
         spike_sin_ff    <= '0;
         spike_half_ff   <= 32'd3373259426;
         mode_flags_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ebmv_pkg::REG_X_SCALE:      x_scale_ff      <= csr_wdata;
            ebmv_pkg::REG_Y_SCALE:      y_scale_ff      <= csr_wdata;
            ebmv_pkg::REG_X_FADE_SCALE: x_fade_scale_ff <= csr_wdata;
            ebmv_pkg::REG_Y_FADE_SCALE: y_fade_scale_ff <= csr_wdata;
            ebmv_pkg::REG_SPIKE_COS:    spike_cos_ff    <= csr_wdata;
            ebmv_pkg::REG_SPIKE_SIN:    spike_sin_ff    <= csr_wdata;
            ebmv_pkg::REG_SPIKE_HALF:   spike_half_ff   <= csr_wdata;
            ebmv_pkg::REG_MODE_FLAGS:   mode_flags_ff   <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Select multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ebmv_pkg::ST_ROT_A: begin
            op_a = ebmv_pkg::MUL_W'($signed(spike_cos_ff));
            op_b = ebmv_pkg::MUL_W'(xr_ff);
         end
         ebmv_pkg::ST_ROT_B: begin
            op_a = ebmv_pkg::MUL_W'($signed(spike_sin_ff));
            op_b = ebmv_pkg::MUL_W'(yr_ff);
         end
         ebmv_pkg::ST_ROT_C: begin
            op_a = ebmv_pkg::MUL_W'($signed(spike_sin_ff));
            op_b = ebmv_pkg::MUL_W'(xr_ff);
         end
         ebmv_pkg::ST_ROT_D: begin
            op_a = ebmv_pkg::MUL_W'($signed(spike_cos_ff));
            op_b = ebmv_pkg::MUL_W'(yr_ff);
         end
         ebmv_pkg::ST_SC0: begin
            op_a = $signed({1'b0, xr_mag});
            op_b = $signed({1'b0, scale_a});
         end
         ebmv_pkg::ST_SC1: begin
            op_a = $signed({1'b0, yr_mag});
            op_b = $signed({1'b0, scale_b});
         end
         ebmv_pkg::ST_SC2: begin
            op_a = $signed({1'b0, u_ff});
            op_b = $signed({1'b0, u_ff});
         end
         ebmv_pkg::ST_SC3: begin
            op_a = $signed({1'b0, v_ff});
            op_b = $signed({1'b0, v_ff});
         end
         ebmv_pkg::ST_RM0: begin
            op_a = $signed({2'b0, m_val});
            op_b = $signed({2'b0, m_val});
         end
         ebmv_pkg::ST_RM1: begin
            op_a = $signed({1'b0, x_scale_ff});
            op_b = $signed({1'b0, y_scale_ff});
         end
         ebmv_pkg::ST_FM0: begin
            op_a = $signed({2'b0, n30_ff});
            op_b = $signed({2'b0, quo_ff});
         end
         default: ;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ebmv_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (mode_flags_ff[0]) begin
                  state_in = ebmv_pkg::ST_DONE;
               end else if (mode_flags_ff[1]) begin
                  state_in = ebmv_pkg::ST_ATAN_INIT;
               end else begin
                  state_in = ebmv_pkg::ST_SC0;
               end
            end
         end
         ebmv_pkg::ST_ATAN_INIT: begin
            if (xr_ff == 0 && yr_ff == 0) begin
               state_in = ebmv_pkg::ST_FOLD_CHK;
            end else begin
               state_in = ebmv_pkg::ST_CORDIC;
            end
         end
         ebmv_pkg::ST_CORDIC: begin
            if (cnt_ff == 5'd29) state_in = ebmv_pkg::ST_FOLD_CHK;
         end
         ebmv_pkg::ST_FOLD_CHK: begin
            if (k_ff < KW'(KMAX) && ang_big) begin
               state_in = ebmv_pkg::ST_ROT_A;
            end else begin
               state_in = ebmv_pkg::ST_SC0;
            end
         end
         ebmv_pkg::ST_ROT_A: state_in = ebmv_pkg::ST_ROT_B;
         ebmv_pkg::ST_ROT_B: state_in = ebmv_pkg::ST_ROT_C;
         ebmv_pkg::ST_ROT_C: state_in = ebmv_pkg::ST_ROT_D;
         ebmv_pkg::ST_ROT_D: state_in = ebmv_pkg::ST_ROT_E;
         ebmv_pkg::ST_ROT_E: state_in = ebmv_pkg::ST_FOLD_CHK;
         ebmv_pkg::ST_SC0:   state_in = ebmv_pkg::ST_SC1;
         ebmv_pkg::ST_SC1:   state_in = ebmv_pkg::ST_SC2;
         ebmv_pkg::ST_SC2:   state_in = ebmv_pkg::ST_SC3;
         ebmv_pkg::ST_SC3:   state_in = ebmv_pkg::ST_SC4;
         ebmv_pkg::ST_SC4: begin
            if (!fade_ff) begin
               state_in = nn_big ? ebmv_pkg::ST_DONE : ebmv_pkg::ST_SC0;
            end else if (nn_big) begin
               state_in = (den == 0) ? ebmv_pkg::ST_FM0 : ebmv_pkg::ST_DIV;
            end else begin
               state_in = tiny ? ebmv_pkg::ST_DONE : ebmv_pkg::ST_RM0;
            end
         end
         ebmv_pkg::ST_RM0: state_in = ebmv_pkg::ST_RM1;
         ebmv_pkg::ST_RM1: state_in = ebmv_pkg::ST_RM2;
         ebmv_pkg::ST_RM2: begin
            if (prod_u == 0 || acc_ff[63:0] >= prod_u) begin
               state_in = ebmv_pkg::ST_RAMP_FIN;
            end else begin
               state_in = ebmv_pkg::ST_DIV;
            end
         end
         ebmv_pkg::ST_DIV: begin
            if (cnt_ff == 5'd1) begin
               state_in = fade_ff ? ebmv_pkg::ST_FM0 : ebmv_pkg::ST_RAMP_FIN;
            end
         end
         ebmv_pkg::ST_RAMP_FIN: state_in = ebmv_pkg::ST_DONE;
         ebmv_pkg::ST_FM0:      state_in = ebmv_pkg::ST_FM1;
         ebmv_pkg::ST_FM1:      state_in = ebmv_pkg::ST_DONE;
         ebmv_pkg::ST_DONE: begin
            if (out_free) state_in = ebmv_pkg::ST_IDLE;
         end
         default: state_in = ebmv_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates
   always_comb begin
      xr_in   = xr_ff;
      yr_in   = yr_ff;
      nx_in   = nx_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      ang_in  = ang_ff;
      cnt_in  = cnt_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      n30_in  = n30_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      fade_in = fade_ff;
      res_in  = res_ff;
      unique case (state_ff)
         ebmv_pkg::ST_IDLE: begin
            xr_in   = sat_c(40'(px_ext));
            yr_in   = sat_c(40'(py_abs));
            k_in    = '0;
            fade_in = 1'b0;
            res_in  = 8'hFF;
         end
         ebmv_pkg::ST_ATAN_INIT: begin
            cnt_in = '0;
            if (xr_ff == 0 && yr_ff == 0) begin
               ang_in = '0;
            end else if (xr_ff < 0) begin
               cx_in  = 36'(yr_ff);
               cy_in  = -36'(xr_ff);
               ang_in = $signed(ebmv_pkg::HALF_PI_Q30);
            end else begin
               cx_in  = 36'(xr_ff);
               cy_in  = 36'(yr_ff);
               ang_in = '0;
            end
         end
         ebmv_pkg::ST_CORDIC: begin
            cnt_in = cnt_ff + 5'd1;
            if (cy_ff >= 0) begin
               cx_in  = cx_ff + dx;
               cy_in  = cy_ff - dy;
               ang_in = ang_ff + $signed({10'b0, ebmv_pkg::ATAN_TAB[cnt_ff]});
            end else begin
               cx_in  = cx_ff - dx;
               cy_in  = cy_ff + dy;
               ang_in = ang_ff - $signed({10'b0, ebmv_pkg::ATAN_TAB[cnt_ff]});
            end
         end
         ebmv_pkg::ST_ROT_B: acc_in = prod;
         ebmv_pkg::ST_ROT_C: nx_in = sat_c(40'($signed(rot_xs[PW-1:30])));
         ebmv_pkg::ST_ROT_D: acc_in = prod;
         ebmv_pkg::ST_ROT_E: begin
            yr_in  = sat_c(40'($signed(rot_ys[PW-1:30])));
            xr_in  = nx_ff;
            ang_in = ang_ff - $signed({7'b0, spike_half_ff, 1'b0});
            k_in   = k_ff + KW'(1);
         end
         ebmv_pkg::ST_SC1: u_in = sat_u;
         ebmv_pkg::ST_SC2: v_in = sat_u;
         ebmv_pkg::ST_SC3: acc_in = prod;
         ebmv_pkg::ST_SC4: begin
            if (!fade_ff) begin
               n30_in  = sum_u[60:30];
               fade_in = 1'b1;
            end else if (nn_big) begin
               dvs_in  = 64'(den);
               rem_in  = num >> 31;
               bits_in = num[30:0];
               cnt_in  = 5'd31;
               quo_in  = '0;
            end else begin
               fade_in = 1'b0;
               res_in  = 8'h00;
            end
         end
         ebmv_pkg::ST_RM1: acc_in = prod <<< 2;
         ebmv_pkg::ST_RM2: begin
            if (prod_u == 0) begin
               quo_in = '0;
            end else if (acc_ff[63:0] >= prod_u) begin
               quo_in = ebmv_pkg::ONE30;
            end else begin
               rem_in  = acc_ff[63:0];
               dvs_in  = prod_u;
               bits_in = '0;
               cnt_in  = 5'd30;
               quo_in  = '0;
            end
         end
         ebmv_pkg::ST_DIV: begin
            rem_in  = div_ge ? diff[63:0] : rem2[63:0];
            quo_in  = {quo_ff[29:0], div_ge};
            bits_in = {bits_ff[29:0], 1'b0};
            cnt_in  = cnt_ff - 5'd1;
         end
         ebmv_pkg::ST_RAMP_FIN: res_in = ramp_prod[37:30];
         ebmv_pkg::ST_FM1:      res_in = ft255[37:30];
         default: ;
      endcase
   end

   // Advance the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ebmv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold datapath values
   always_ff @(posedge clock) begin
      xr_ff   <= xr_in;
      yr_ff   <= yr_in;
      nx_ff   <= nx_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      ang_ff  <= ang_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      n30_ff  <= n30_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      fade_ff <= fade_in;
      res_ff  <= res_in;
   end

   // Load the output register when it is free, drop valid once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ebmv_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ebmv_pkg::ST_DONE && out_free) begin
         rsp_mask_ff <= res_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mask_value = rsp_mask_ff;

   // Fold count stays within the cap
   a_fold_cap: assert property (@(posedge clock) disable iff (reset)
      k_ff <= KW'(KMAX) || state_ff == ebmv_pkg::ST_IDLE
      || state_ff == ebmv_pkg::ST_DONE)
      else $error("fold count above cap");

   // Partial remainder stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ebmv_pkg::ST_DIV |-> rem_ff < dvs_ff)
      else $error("divider remainder out of range");

   // Fade ratio never exceeds one
   a_fade_ratio: assert property (@(posedge clock) disable iff (reset)
      state_ff == ebmv_pkg::ST_FM0 |-> quo_ff <= ebmv_pkg::ONE30)
      else $error("fade ratio above one");

   // A finished item shows up at the output next cycle
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ebmv_pkg::ST_DONE && out_free) |=> rsp_valid_ff
      && state_ff == ebmv_pkg::ST_IDLE)
      else $error("result not presented");

endmodule

FILE: hw/rtl/ebmv_mul.sv
module ebmv_mul (
   input  logic                                  clock,
   input  logic signed [ebmv_pkg::MUL_W-1:0]     op_a,
   input  logic signed [ebmv_pkg::MUL_W-1:0]     op_b,
   output logic signed [2*ebmv_pkg::MUL_W-1:0]   prod
);

   logic signed [2*ebmv_pkg::MUL_W-1:0] prod_ff;
   logic signed [2*ebmv_pkg::MUL_W-1:0] prod_in;

   // Form the full signed product
   assign prod_in = (2*ebmv_pkg::MUL_W)'(op_a) * (2*ebmv_pkg::MUL_W)'(op_b);

   // Register the product for the next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: verif/ebmv_checker.sv
module ebmv_checker #(
   parameter int MAX_SPIKES = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [COORD_BITS-1:0] req_pos_x,
   input  logic [COORD_BITS-1:0] req_pos_y,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [7:0]            rsp_mask_value,
   input  logic                  csr_we,
   input  logic [3:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    beats_in
);

   localparam int EXT = (COORD_BITS < 31) ? 31 - COORD_BITS : 0;
   localparam longint CLAMP = 64'sd2147483647;
   localparam longint unsigned UNIT = 64'd1 << 30;

   // shadow copy of the register file
   logic [31:0] sh_x_scale, sh_y_scale, sh_x_fade, sh_y_fade;
   logic [31:0] sh_cos, sh_sin, sh_half;
   logic [2:0]  sh_mode;

   logic [7:0] mask_q[$];

   assign outstanding = mask_q.size();

   function automatic longint clamp31(longint v);
      if (v > CLAMP) return CLAMP;
      if (v < -CLAMP) return -CLAMP;
      return v;
   endfunction

   // vectoring arctangent for y >= 0, Q2.30 in [0, pi]
   function automatic longint point_angle(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         z = longint'(ebmv_pkg::HALF_PI_Q30);
      end
      for (int i = 0; i < 30; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + longint'(ebmv_pkg::ATAN_TAB[i]);
         end else begin
            x = x - dx; y = y + dy; z = z - longint'(ebmv_pkg::ATAN_TAB[i]);
         end
      end
      return z;
   endfunction

   function automatic longint unsigned scaled_coord(longint c, logic [31:0] s);
      longint unsigned mag, sv, p;
      mag = (c < 0) ? longint'(-c) : longint'(c);
      sv = {32'd0, s};
      p = (mag * sv) >> (4 + EXT);
      return (p > (64'd1 << 31)) ? (64'd1 << 31) : p;
   endfunction

   // floor(q * 2^30 / p) for q < p, 2^30 for q >= p, 0 for p == 0
   function automatic longint unsigned frac_div(longint unsigned q, longint unsigned p);
      logic [64:0] rem;
      longint unsigned quot;
      if (p == 0) return 0;
      if (q >= p) return UNIT;
      rem = {1'b0, q};
      quot = 0;
      for (int i = 0; i < 30; i++) begin
         rem = rem << 1;
         quot = quot << 1;
         if (rem >= {1'b0, p}) begin
            rem = rem - {1'b0, p};
            quot = quot | 64'd1;
         end
      end
      return quot;
   endfunction

   function automatic logic [7:0] mask_for(logic signed [COORD_BITS-1:0] px,
                                            logic signed [COORD_BITS-1:0] py);
      longint xr, yr, sx, sy, ang, half, cs, ss;
      longint unsigned u, v, nn, n30, ff, f30, den, r, m, res;
      if (sh_mode[0]) return 8'd255;
      xr = clamp31(longint'(px) * (64'sd1 <<< EXT));
      yr = longint'(py) * (64'sd1 <<< EXT);
      if (yr < 0) yr = -yr;
      yr = clamp31(yr);
      // fold the point into the first spike
      if (sh_mode[1]) begin
         ang = point_angle(yr, xr);
         half = longint'({32'd0, sh_half});
         cs = longint'(signed'(sh_cos));
         ss = longint'(signed'(sh_sin));
         for (int k = 0; k < MAX_SPIKES / 2; k++) begin
            if (ang > half) begin
               sx = xr;
               sy = yr;
               xr = clamp31((cs * sx - ss * sy + (64'sd1 <<< 29)) >>> 30);
               yr = clamp31((ss * sx + cs * sy + (64'sd1 <<< 29)) >>> 30);
               ang = ang - 2 * half;
            end
         end
      end
      u = scaled_coord(xr, sh_x_scale);
      v = scaled_coord(yr, sh_y_scale);
      nn = u * u + v * v;
      if (nn > (64'd1 << 60)) return 8'd255;
      n30 = nn >> 30;
      u = scaled_coord(xr, sh_x_fade);
      v = scaled_coord(yr, sh_y_fade);
      ff = u * u + v * v;
      if (ff > (64'd1 << 60)) begin
         f30 = ff >> 30;
         den = f30 - n30;
         r = (den == 0) ? 64'd0 : ((f30 - UNIT) << 30) / den;
         res = n30 * r;
         res = res >> 30;
         res = res * 64'd255;
         res = res >> 30;
      end else begin
         m = UNIT - n30;
         if (sh_mode[2] || 2 * m > {32'd0, sh_x_scale} || 2 * m > {32'd0, sh_y_scale}) begin
            res = 0;
         end else begin
            r = frac_div(4 * m * m, {32'd0, sh_x_scale} * {32'd0, sh_y_scale});
            res = (64'd255 * (UNIT - r)) >> 30;
         end
      end
      return res[7:0];
   endfunction

   // track registers, predict accepted beats, compare results
   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         sh_x_scale = 0; sh_y_scale = 0; sh_x_fade = 0; sh_y_fade = 0;
         sh_cos = 32'h4000_0000; sh_sin = 0; sh_half = 32'd3373259426; sh_mode = 0;
         mask_q.delete();
         fail_count <= 0;
         beats_in <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ebmv_pkg::REG_X_SCALE:      sh_x_scale = csr_wdata;
               ebmv_pkg::REG_Y_SCALE:      sh_y_scale = csr_wdata;
               ebmv_pkg::REG_X_FADE_SCALE: sh_x_fade = csr_wdata;
               ebmv_pkg::REG_Y_FADE_SCALE: sh_y_fade = csr_wdata;
               ebmv_pkg::REG_SPIKE_COS:    sh_cos = csr_wdata;
               ebmv_pkg::REG_SPIKE_SIN:    sh_sin = csr_wdata;
               ebmv_pkg::REG_SPIKE_HALF:   sh_half = csr_wdata;
               ebmv_pkg::REG_MODE_FLAGS:   sh_mode = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            mask_q.push_back(mask_for(req_pos_x, req_pos_y));
            beats_in <= beats_in + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (mask_q.size() == 0) begin
               $error("mask_value: result beat with no expectation, actual %0d",
                      rsp_mask_value);
               fail_count <= fail_count + 1;
            end else begin
               want = mask_q.pop_front();
               if (rsp_mask_value !== want) begin
                  $error("mask_value mismatch: expected %0d, actual %0d",
                         want, rsp_mask_value);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

FILE: verif/tb_elliptic_brush_mask_value.sv
module tb_elliptic_brush_mask_value;

   localparam int  PHASES = 8;
   localparam int  PHASE_BEATS = 225;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam real PI = 3.14159265358979;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_pos_x;
   logic [15:0] req_pos_y;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_mask_value;
   logic        csr_we;
   logic [3:0]  csr_index;
   logic [31:0] csr_wdata;

   int     fail_count, outstanding, beats_in;
   int     settings;
   int     hold_cycles;
   bit     quiet;
   longint cycles = 0;

   elliptic_brush_mask_value dut (.*);

   ebmv_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mask_value(rsp_mask_value),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding), .beats_in(beats_in)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // abort on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stall, plus a long hold when asked
   initial begin
      int left;
      rsp_stall = 1'b0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (left > 0) begin
            left = left - 1;
            rsp_stall <= 1'b1;
         end else begin
            left = gap_len();
            rsp_stall <= (left > 0);
            if (left > 0) left = left - 1;
         end
      end
   end

   // offer one beat, hold it until accepted, then maybe drop valid for a gap
   task automatic send_point(logic [15:0] px, logic [15:0] py);
      int g;
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      do @(posedge clock); while (req_stall);
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(logic [3:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // brush of given width, aspect, fade factor and spike count
   task automatic setup_brush(int width, int aspect_pct, int fade_pct, int spikes,
                              logic [2:0] mode);
      longint unsigned xs, ys;
      real step;
      xs = (64'd1 << 31) / width;
      ys = (xs * 100) / aspect_pct;
      if (ys > 64'hFFFF_FFFF) ys = 64'hFFFF_FFFF;
      step = 2.0 * PI / spikes;
      set_reg(ebmv_pkg::REG_X_SCALE, xs[31:0]);
      set_reg(ebmv_pkg::REG_Y_SCALE, ys[31:0]);
      set_reg(ebmv_pkg::REG_X_FADE_SCALE, 32'((xs * fade_pct) / 100));
      set_reg(ebmv_pkg::REG_Y_FADE_SCALE, 32'((ys * fade_pct) / 100));
      set_reg(ebmv_pkg::REG_SPIKE_COS, 32'($rtoi($cos(step) * 1073741824.0)));
      set_reg(ebmv_pkg::REG_SPIKE_SIN, 32'($rtoi($sin(step) * 1073741824.0)));
      set_reg(ebmv_pkg::REG_SPIKE_HALF, 32'($rtoi(step / 2.0 * 1073741824.0)));
      set_reg(ebmv_pkg::REG_MODE_FLAGS, {29'd0, mode});
      settings++;
   endtask

   // point near the brush of the given pixel width, or anywhere
   task automatic random_point(int width);
      int span;
      span = width * 12 + 2;
      if ($urandom_range(0, 99) < 75)
         send_point(16'($urandom_range(0, 2 * span) - span),
                    16'($urandom_range(0, 2 * span) - span));
      else
         send_point(16'($urandom), 16'($urandom));
   endtask

   initial begin
      int w;
      logic [2:0] mode;
      hold_cycles = 0;
      quiet = 1'b0;
      settings = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: all scales zero
      send_point(16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h8000);
      drain();

      // plain ellipse: origin, extremes, edge region
      setup_brush(40, 100, 150, 6, 3'b000);
      send_point(16'h0000, 16'h0000);
      send_point(16'h7FFF, 16'h7FFF);
      send_point(16'h8000, 16'h8000);
      send_point(16'h8000, 16'h7FFF);
      send_point(16'd300, 16'd10);
      send_point(16'd318, 16'h0000);
      send_point(16'd100, -16'sd120);
      drain();
      // spiked: origin angle, folding, negative x
      setup_brush(40, 60, 130, 6, 3'b010);
      send_point(16'h0000, 16'h0000);
      send_point(-16'sd200, 16'd50);
      send_point(16'd10, 16'd250);
      send_point(-16'sd300, -16'sd5);
      drain();
      // rotation cap with zero half angle
      set_reg(ebmv_pkg::REG_SPIKE_HALF, 32'd0);
      send_point(-16'sd150, 16'd90);
      send_point(16'd40, 16'd40);
      drain();
      // tiny brush and empty brush
      setup_brush(1, 100, 150, 3, 3'b100);
      send_point(16'd3, 16'd2);
      send_point(16'h0000, 16'h0001);
      drain();
      set_reg(ebmv_pkg::REG_MODE_FLAGS, 32'd7);
      send_point(16'd3, 16'd2);
      send_point(16'h8000, 16'h7FFF);
      drain();
      // extreme scales
      set_reg(ebmv_pkg::REG_X_SCALE, 32'hFFFF_FFFF);
      set_reg(ebmv_pkg::REG_Y_SCALE, 32'hFFFF_FFFF);
      set_reg(ebmv_pkg::REG_X_FADE_SCALE, 32'hFFFF_FFFF);
      set_reg(ebmv_pkg::REG_Y_FADE_SCALE, 32'h0000_0000);
      set_reg(ebmv_pkg::REG_SPIKE_COS, 32'hC000_0000);
      set_reg(ebmv_pkg::REG_SPIKE_SIN, 32'h4000_0000);
      set_reg(ebmv_pkg::REG_MODE_FLAGS, 32'd2);
      send_point(16'd1, 16'd1);
      send_point(-16'sd1, 16'h0000);
      send_point(16'd5, 16'd3);
      drain();

      // random phases with varied brushes
      for (int p = 0; p < PHASES; p++) begin
         w = (p == PHASES - 1) ? 2000 : $urandom_range(2, 120);
         mode = 3'($urandom_range(0, 7));
         if (mode[0] && $urandom_range(0, 3) != 0) mode[0] = 1'b0;
         if (p == 1) mode = 3'b010;
         setup_brush(w, $urandom_range(20, 300), $urandom_range(60, 400),
                     $urandom_range(3, 32), mode);
         if (p == 3 && $urandom_range(0, 1)) set_reg(ebmv_pkg::REG_SPIKE_HALF, 32'hC910_0000);
         quiet = (p == 2);
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // long receiver hold while beats keep coming
            if (p == 4 && i == 20) hold_cycles = 600;
            // sender waits for every result once
            if (p == 5 && i == 100) begin
               req_valid <= 1'b0;
               @(posedge clock);
               wait (outstanding == 0);
            end
            random_point(w);
         end
         quiet = 1'b0;
         drain();
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d beats over %0d brush settings, spiked, tiny and empty modes.",
               beats_in, settings);
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
